[src/ir_pulse_distance_receiver_assert.svh]
// Assertion macros shared by the checker
`ifndef IR_PULSE_DISTANCE_RECEIVER_ASSERT_SVH
`define IR_PULSE_DISTANCE_RECEIVER_ASSERT_SVH

// same-cycle implication
`define IRD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IRD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/ird_pkg.sv]
`timescale 1ns / 1ps
package ird_pkg;

   localparam int unsigned STAMP_W = 16;
   localparam int unsigned LIMIT_W = 15;
   localparam int unsigned TICKS_W = 8;
   localparam int unsigned COUNT_W = 6;
   localparam int unsigned CODE_W  = 32;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic MODE_EDGE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   localparam logic [COUNT_W-1:0] EDGE_HDR2       = 6'd1;
   localparam logic [COUNT_W-1:0] EDGE_DATA_FIRST = 6'd2;
   localparam logic [COUNT_W-1:0] EDGE_DATA_LAST  = 6'd33;
   localparam logic [COUNT_W-1:0] EDGE_TRAILER    = 6'd34;
   localparam logic [COUNT_W-1:0] EDGE_LAST       = 6'd35;

   localparam logic [CODE_W-1:0] CODE_MSB = 32'h8000_0000;

   localparam logic [STAMP_W-1:0] TIMER_TOP_RST  = 16'd65535;
   localparam logic [LIMIT_W-1:0] SHORT_GAP_RST  = 15'd100;
   localparam logic [TICKS_W-1:0] TIMEOUT_RST    = 8'd200;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMER_TOP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_GAP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 2'd2;

   typedef struct packed {
      logic [STAMP_W-1:0] timer_top;
      logic [LIMIT_W-1:0] short_gap_limit;
      logic [TICKS_W-1:0] timeout_ticks;
   } ird_cfg_type;

   typedef struct packed {
      logic              emit;
      logic [CODE_W-1:0] code;
   } ird_result_type;

endpackage

[src/ird_csr.sv]
`timescale 1ns / 1ps
module ird_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [ird_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ird_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output ird_pkg::ird_cfg_type             cfg
);
   import ird_pkg::*;

   ird_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TIMER_TOP: cfg_in.timer_top       = csr_write_data;
            CSR_SHORT_GAP: cfg_in.short_gap_limit = csr_write_data[LIMIT_W-1:0];
            CSR_TIMEOUT:   cfg_in.timeout_ticks   = csr_write_data[TICKS_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timer_top       <= TIMER_TOP_RST;
         cfg_ff.short_gap_limit <= SHORT_GAP_RST;
         cfg_ff.timeout_ticks   <= TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/ird_gap_decode.sv]
`timescale 1ns / 1ps
module ird_gap_decode (
   input  logic [ird_pkg::STAMP_W-1:0] stamp,
   input  logic [ird_pkg::STAMP_W-1:0] last_stamp,
   input  ird_pkg::ird_cfg_type        cfg,
   output logic                        is_one
);
   import ird_pkg::*;

   logic [STAMP_W-1:0] gap_raw;
   logic [STAMP_W-1:0] gap_fix;

   // negative gap: timer wrapped, add the wrap value once
   always_comb begin
      gap_raw = stamp - last_stamp;
      gap_fix = gap_raw[STAMP_W-1] ? (gap_raw + cfg.timer_top) : gap_raw;
      is_one  = !gap_fix[STAMP_W-1] && (gap_fix[LIMIT_W-1:0] <= cfg.short_gap_limit);
   end

endmodule

[src/ird_frame.sv]
`timescale 1ns / 1ps
module ird_frame (
   input  logic                        clock,
   input  logic                        reset,
   input  ird_pkg::ird_cfg_type        cfg,
   input  logic                        advance,
   input  logic                        mode,
   input  logic [ird_pkg::STAMP_W-1:0] stamp,
   output ird_pkg::ird_result_type     result
);
   import ird_pkg::*;

   logic [STAMP_W-1:0] last_stamp_ff, last_stamp_in;
   logic [COUNT_W-1:0] edge_count_ff, edge_count_in;
   logic [CODE_W-1:0]  code_shift_ff, code_shift_in;
   logic               armed_ff, armed_in;
   logic [TICKS_W-1:0] idle_ticks_ff, idle_ticks_in;

   logic [TICKS_W-1:0] idle_plus;
   logic [COUNT_W-1:0] bit_pos;
   logic               is_one;

   ird_gap_decode u_gap (
      .stamp      (stamp),
      .last_stamp (last_stamp_ff),
      .cfg        (cfg),
      .is_one     (is_one)
   );

   assign result.emit = (mode == MODE_EDGE) && (edge_count_ff == EDGE_LAST);
   assign result.code = code_shift_ff;

   always_comb begin
      last_stamp_in = last_stamp_ff;
      edge_count_in = edge_count_ff;
      code_shift_in = code_shift_ff;
      armed_in      = armed_ff;
      idle_ticks_in = idle_ticks_ff;
      idle_plus     = idle_ticks_ff + 8'd1;
      bit_pos       = edge_count_ff - EDGE_DATA_FIRST;
      if (advance) begin
         if (mode == MODE_TICK) begin
            if (armed_ff) begin
               idle_ticks_in = idle_plus;
               if (idle_plus >= cfg.timeout_ticks) begin
                  edge_count_in = '0;
                  code_shift_in = '0;
                  armed_in      = 1'b0;
                  idle_ticks_in = '0;
               end
            end
         end else begin
            last_stamp_in = stamp;
            idle_ticks_in = '0;
            unique case (edge_count_ff) inside
               EDGE_LAST: begin
                  armed_in      = 1'b0;
                  edge_count_in = '0;
               end
               EDGE_TRAILER, EDGE_HDR2: begin
                  edge_count_in = edge_count_ff + 6'd1;
               end
               [EDGE_DATA_FIRST:EDGE_DATA_LAST]: begin
                  if (is_one) begin
                     code_shift_in = code_shift_ff | (CODE_MSB >> bit_pos);
                  end
                  edge_count_in = edge_count_ff + 6'd1;
               end
               default: begin
                  armed_in      = 1'b1;
                  code_shift_in = '0;
                  edge_count_in = EDGE_HDR2;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_stamp_ff <= '0;
         edge_count_ff <= '0;
         code_shift_ff <= '0;
         armed_ff      <= 1'b0;
         idle_ticks_ff <= '0;
      end else begin
         last_stamp_ff <= last_stamp_in;
         edge_count_ff <= edge_count_in;
         code_shift_ff <= code_shift_in;
         armed_ff      <= armed_in;
         idle_ticks_ff <= idle_ticks_in;
      end
   end

endmodule

[src/ir_pulse_distance_receiver.sv]
// Path: an accepted request is held in the input register, then a finished code is held in
// the result register; rsp_valid and rsp_code are driven from the result register.
// Throughput: one request per cycle; the input stage stalls only while a finished
// code waits in the result register, rsp_ready is low and another code is ready behind it.
// Reset (synchronous, active high): frame state cleared, timeout stopped,
// registers back to timer_top 65535, short_gap_limit 100, timeout_ticks 200.
`timescale 1ns / 1ps
module ir_pulse_distance_receiver (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_mode,
   input  logic [ird_pkg::STAMP_W-1:0]      req_capture_stamp,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ird_pkg::CODE_W-1:0]       rsp_code,
   input  logic                             csr_write_enable,
   input  logic [ird_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ird_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import ird_pkg::*;

   ird_cfg_type    cfg;
   ird_result_type result;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_mode_ff;
   logic [STAMP_W-1:0] s1_stamp_ff;
   logic               out_valid_ff, out_valid_in;
   logic [CODE_W-1:0]  out_code_ff;
   logic               advance;
   logic               req_fire;

   ird_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ird_frame u_frame (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (advance),
      .mode    (s1_mode_ff),
      .stamp   (s1_stamp_ff),
      .result  (result)
   );

   assign advance   = s1_valid_ff && (!result.emit || !out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance && result.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff  <= req_mode;
         s1_stamp_ff <= req_capture_stamp;
      end
      if (advance && result.emit) begin
         out_code_ff <= result.code;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_code  = out_code_ff;

endmodule

[src/ird_checker.sv]
`timescale 1ns / 1ps
`include "ir_pulse_distance_receiver_assert.svh"
module ird_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             req_mode,
   input logic [ird_pkg::STAMP_W-1:0]      req_capture_stamp,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [ird_pkg::CODE_W-1:0]       rsp_code,
   input logic                             csr_write_enable,
   input logic [ird_pkg::CSR_IDX_W-1:0]    csr_index,
   input logic [ird_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import ird_pkg::*;

   `IRD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_code), "rsp dropped or changed while stalled")
   `IRD_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "rsp_valid after reset")
   `IRD_ASSERT_IMP(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "request stalled with empty result register")
   `IRD_ASSERT_IMP(a_rsp_has_request, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2), "result without an accepted request")

endmodule

bind ir_pulse_distance_receiver ird_checker u_checker (.*);
